// ----- rtl/core/cdc_pkg.sv -----
package cdc_pkg;

  // Compact word layout
  localparam int unsigned CompactW = 32;
  localparam int unsigned ExpW     = 8;
  localparam int unsigned MantW    = 23;
  localparam int unsigned NormMantW = 24;

  // Wide value layout
  localparam int unsigned WordW    = 64;
  localparam int unsigned ValueW   = 256;
  localparam int unsigned NumBytes = ValueW / 8;
  localparam int unsigned SizeW    = $clog2(NumBytes + 1);
  localparam int unsigned PosW     = $clog2(NumBytes);

  // Largest exponent plus significant mantissa bytes that still fits
  localparam logic [ExpW:0] ExpLimit = (ExpW + 1)'(NumBytes + 3);
  localparam logic [ExpW-1:0] ExpBias = ExpW'(3);

  // Item kinds
  typedef enum logic {
    KIND_DECODE = 1'b0,
    KIND_ENCODE = 1'b1
  } kind_e;

  // Stage 1 -> stage 2 payload
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              ovf;
  } dec_t;

  // Stage 2 -> stage 3 payload
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              ovf;
    logic [SizeW-1:0]  size;
  } scan_t;

  // Stage 3 result payload
  typedef struct packed {
    logic [ValueW-1:0]   value;
    logic                ovf;
    logic [CompactW-1:0] normal;
  } res_t;

  // Input item payload
  typedef struct packed {
    logic                kind;
    logic [CompactW-1:0] compact_word;
    logic [ValueW-1:0]   big;
  } item_t;

endpackage

// ----- rtl/core/cdc_if.sv -----
interface cdc_in_if;
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic [cdc_pkg::CompactW-1:0]       compact_word;
  logic [cdc_pkg::WordW-1:0]          big_word_0;
  logic [cdc_pkg::WordW-1:0]          big_word_1;
  logic [cdc_pkg::WordW-1:0]          big_word_2;
  logic [cdc_pkg::WordW-1:0]          big_word_3;

  modport source (output valid, kind, compact_word, big_word_0, big_word_1,
                  big_word_2, big_word_3, input ready);
  modport sink   (input valid, kind, compact_word, big_word_0, big_word_1,
                  big_word_2, big_word_3, output ready);
endinterface

interface cdc_out_if;
  logic                               valid;
  logic                               ready;
  logic [cdc_pkg::WordW-1:0]          value_word_0;
  logic [cdc_pkg::WordW-1:0]          value_word_1;
  logic [cdc_pkg::WordW-1:0]          value_word_2;
  logic [cdc_pkg::WordW-1:0]          value_word_3;
  logic                               overflow_flag;
  logic [cdc_pkg::CompactW-1:0]       normal_word;

  modport source (output valid, value_word_0, value_word_1, value_word_2,
                  value_word_3, overflow_flag, normal_word, input ready);
  modport sink   (input valid, value_word_0, value_word_1, value_word_2,
                  value_word_3, overflow_flag, normal_word, output ready);
endinterface

// ----- rtl/core/cdc_decode.sv -----
module cdc_decode (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  cdc_pkg::item_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output cdc_pkg::dec_t  data_o
);

  logic                        valid_q, valid_d;
  cdc_pkg::dec_t               data_q, data_d;
  logic [cdc_pkg::ExpW-1:0]    expo;
  logic                        sgn;
  logic [cdc_pkg::MantW-1:0]   mant;
  logic [1:0]                  sig;
  logic                        ovf;
  logic [cdc_pkg::ExpW-1:0]    lshift;
  logic [1:0]                  rbytes;
  logic [cdc_pkg::ValueW-1:0]  mant_ext;

  // Split the compact word
  assign expo = data_i.compact_word[cdc_pkg::CompactW-1 -: cdc_pkg::ExpW];
  assign sgn  = data_i.compact_word[cdc_pkg::MantW];
  assign mant = data_i.compact_word[cdc_pkg::MantW-1:0];
  assign mant_ext = {{(cdc_pkg::ValueW - cdc_pkg::MantW){1'b0}}, mant};

  // Count significant mantissa bytes
  always_comb begin
    priority if (mant > 23'h00ffff) begin
      sig = 2'd3;
    end else if (mant > 23'h0000ff) begin
      sig = 2'd2;
    end else if (mant != '0) begin
      sig = 2'd1;
    end else begin
      sig = 2'd0;
    end
  end

  // Flag mantissas pushed past the top byte
  assign ovf = !sgn && (mant != '0) &&
               (({1'b0, expo} + {{(cdc_pkg::ExpW - 1){1'b0}}, sig}) > cdc_pkg::ExpLimit);

  assign lshift = expo - cdc_pkg::ExpBias;
  assign rbytes = 2'd3 - expo[1:0];

  // Expand or pass through the value
  always_comb begin
    data_d.ovf = 1'b0;
    if (data_i.kind == cdc_pkg::KIND_ENCODE) begin
      data_d.value = data_i.big;
    end else if (sgn || ovf) begin
      data_d.value = '0;
      data_d.ovf   = ovf;
    end else if (expo <= cdc_pkg::ExpBias) begin
      data_d.value = mant_ext >> {rbytes, 3'b000};
    end else begin
      data_d.value = mant_ext << {lshift[cdc_pkg::PosW-1:0], 3'b000};
    end
  end

  // Advance when empty or when downstream takes the held transaction
  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/core/cdc_scan.sv -----
module cdc_scan (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  cdc_pkg::dec_t  data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output cdc_pkg::scan_t data_o
);

  logic                          valid_q, valid_d;
  cdc_pkg::scan_t                data_q, data_d;
  logic [cdc_pkg::NumBytes-1:0]  nz;
  logic [cdc_pkg::SizeW-1:0]     size;

  // Mark nonzero bytes
  always_comb begin
    for (int i = 0; i < cdc_pkg::NumBytes; i++) begin
      nz[i] = data_i.value[i*8 +: 8] != 8'h00;
    end
  end

  // Find the highest nonzero byte
  always_comb begin
    size = '0;
    for (int i = 0; i < cdc_pkg::NumBytes; i++) begin
      if (nz[i]) begin
        size = cdc_pkg::SizeW'(i + 1);
      end
    end
  end

  assign data_d.value = data_i.value;
  assign data_d.ovf   = data_i.ovf;
  assign data_d.size  = size;

  // Advance when empty or when downstream takes the held transaction
  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/core/cdc_norm.sv -----
module cdc_norm (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  cdc_pkg::scan_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output cdc_pkg::res_t  data_o
);

  logic                              valid_q, valid_d;
  cdc_pkg::res_t                     data_q, data_d;
  logic [cdc_pkg::ValueW+15:0]       ext;
  logic [cdc_pkg::ValueW+15:0]       shifted;
  logic [cdc_pkg::SizeW-1:0]         size_m1;
  logic [cdc_pkg::NormMantW-1:0]     win;
  logic [cdc_pkg::NormMantW-1:0]     mant;
  logic [cdc_pkg::ExpW-1:0]          expo;

  // Pull the three top significant bytes, zero below byte zero
  assign ext     = {data_i.value, 16'h0000};
  assign size_m1 = data_i.size - cdc_pkg::SizeW'(1);
  assign shifted = ext >> {size_m1[cdc_pkg::PosW-1:0], 3'b000};
  assign win     = (data_i.size == '0) ? '0 : shifted[cdc_pkg::NormMantW-1:0];

  // Bump the exponent when the top mantissa bit would read as sign
  always_comb begin
    expo = {{(cdc_pkg::ExpW - cdc_pkg::SizeW){1'b0}}, data_i.size};
    mant = win;
    if (win[cdc_pkg::MantW]) begin
      expo = expo + cdc_pkg::ExpW'(1);
      mant = win >> 8;
    end
  end

  assign data_d.value  = data_i.value;
  assign data_d.ovf    = data_i.ovf;
  assign data_d.normal = {expo, mant};

  // Hold the result until the sink takes it
  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/core/compact_target_codec.sv -----
// Channel | Dir | Payload
// in_i    | in  | kind, compact_word, big_word_0..3
// out_o   | out | value_word_0..3, overflow_flag, normal_word
//
// Three register stages: decode/shift, highest-byte scan, normalize.
// One transaction per cycle while out_o is not stalled; an accepted transaction passes through
// the decode, scan and normalize registers in that order. rst_ni clears the stage valid bits
// only; payload registers are not reset. A stall at out_o holds each full stage in place; empty stages keep filling.
module compact_target_codec (
  input  logic         clk_i,
  input  logic         rst_ni,
  cdc_in_if.sink       in_i,
  cdc_out_if.source    out_o
);

  cdc_pkg::item_t item;
  cdc_pkg::dec_t  dec;
  cdc_pkg::scan_t scan;
  cdc_pkg::res_t  res;
  logic           dec_valid, dec_ready;
  logic           scan_valid, scan_ready;

  // Gather the input transaction
  assign item.kind         = in_i.kind;
  assign item.compact_word = in_i.compact_word;
  assign item.big          = {in_i.big_word_3, in_i.big_word_2,
                              in_i.big_word_1, in_i.big_word_0};

  cdc_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .data_i  (item),
    .valid_o (dec_valid),
    .ready_i (dec_ready),
    .data_o  (dec)
  );

  cdc_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .ready_o (dec_ready),
    .data_i  (dec),
    .valid_o (scan_valid),
    .ready_i (scan_ready),
    .data_o  (scan)
  );

  cdc_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (scan_valid),
    .ready_o (scan_ready),
    .data_i  (scan),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (res)
  );

  // Drive the result transaction
  assign out_o.value_word_0  = res.value[0*cdc_pkg::WordW +: cdc_pkg::WordW];
  assign out_o.value_word_1  = res.value[1*cdc_pkg::WordW +: cdc_pkg::WordW];
  assign out_o.value_word_2  = res.value[2*cdc_pkg::WordW +: cdc_pkg::WordW];
  assign out_o.value_word_3  = res.value[3*cdc_pkg::WordW +: cdc_pkg::WordW];
  assign out_o.overflow_flag = res.ovf;
  assign out_o.normal_word   = res.normal;

endmodule

// ----- verif/compact_target_codec_test.sv -----
`timescale 1ns / 100ps

module compact_target_codec_test;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomItems = 850;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned DrainCycles = 8;

  // Expected conversions, in order of acceptance
  class conversion_checker;
    cdc_pkg::res_t expected_conversions[$];
    int unsigned   mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    // Normalized compact form of a 256-bit value
    function logic [cdc_pkg::CompactW-1:0] compact_form(logic [cdc_pkg::ValueW-1:0] v);
      int unsigned                    size;
      logic [cdc_pkg::ValueW-1:0]     aligned;
      logic [cdc_pkg::NormMantW-1:0]  mant;
      logic [cdc_pkg::ExpW-1:0]       expo;
      size = 0;
      for (int i = cdc_pkg::NumBytes - 1; i >= 0; i--) begin
        if (v[8*i +: 8] != 8'h00) begin
          size = i + 1;
          break;
        end
      end
      // Pick the top three significant bytes, zeros below byte zero
      if (size >= 3) aligned = v >> (8 * (size - 3));
      else aligned = v << (8 * (3 - size));
      mant = aligned[cdc_pkg::NormMantW-1:0];
      expo = cdc_pkg::ExpW'(size);
      if (mant[cdc_pkg::NormMantW-1]) begin
        expo = expo + 1'b1;
        mant = mant >> 8;
      end
      return {expo, mant};
    endfunction

    // Expand or pass through the value, then attach its normal form
    function cdc_pkg::res_t expand_and_normalize(cdc_pkg::item_t it);
      cdc_pkg::res_t              r;
      logic [cdc_pkg::MantW-1:0]  m;
      int                         e;
      int                         sig;
      r.value = '0;
      r.ovf   = 1'b0;
      if (it.kind == cdc_pkg::KIND_ENCODE) begin
        r.value = it.big;
      end else if (!it.compact_word[cdc_pkg::MantW]) begin
        m = it.compact_word[cdc_pkg::MantW-1:0];
        e = int'(it.compact_word[cdc_pkg::CompactW-1 -: cdc_pkg::ExpW]);
        if (e <= 3) begin
          r.value = cdc_pkg::ValueW'(m) >> (8 * (3 - e));
        end else if (m != '0) begin
          sig = (m > 23'h00ffff) ? 3 : ((m > 23'h0000ff) ? 2 : 1);
          if (e > 35 - sig) r.ovf = 1'b1;
          else r.value = cdc_pkg::ValueW'(m) << (8 * (e - 3));
        end
      end
      r.normal = compact_form(r.value);
      return r;
    endfunction

    function void note_input(cdc_pkg::item_t it);
      expected_conversions.push_back(expand_and_normalize(it));
    endfunction

    function void compare_field(string field, logic [cdc_pkg::ValueW-1:0] want,
                                logic [cdc_pkg::ValueW-1:0] got);
      if (want !== got) begin
        mismatch_count++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_result(cdc_pkg::res_t got);
      cdc_pkg::res_t want;
      if (expected_conversions.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual value %0h normal %0h",
                 $time, got.value, got.normal);
        return;
      end
      want = expected_conversions.pop_front();
      compare_field("value_word_0", cdc_pkg::ValueW'(want.value[63:0]),
                    cdc_pkg::ValueW'(got.value[63:0]));
      compare_field("value_word_1", cdc_pkg::ValueW'(want.value[127:64]),
                    cdc_pkg::ValueW'(got.value[127:64]));
      compare_field("value_word_2", cdc_pkg::ValueW'(want.value[191:128]),
                    cdc_pkg::ValueW'(got.value[191:128]));
      compare_field("value_word_3", cdc_pkg::ValueW'(want.value[255:192]),
                    cdc_pkg::ValueW'(got.value[255:192]));
      compare_field("overflow_flag", cdc_pkg::ValueW'(want.ovf), cdc_pkg::ValueW'(got.ovf));
      compare_field("normal_word", cdc_pkg::ValueW'(want.normal),
                    cdc_pkg::ValueW'(got.normal));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   src_calm;
  bit   sink_calm;
  int unsigned cycle_count;

  conversion_checker checker_h;

  cdc_in_if  in_if ();
  cdc_out_if out_if ();

  compact_target_codec i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Clock generation
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [cdc_pkg::ValueW-1:0] random_value();
    logic [cdc_pkg::ValueW-1:0] v;
    for (int i = 0; i < cdc_pkg::ValueW / 32; i++) v[32*i +: 32] = $urandom;
    return v;
  endfunction

  function automatic cdc_pkg::item_t decode_item(logic [cdc_pkg::CompactW-1:0] cw);
    cdc_pkg::item_t it;
    it.kind         = cdc_pkg::KIND_DECODE;
    it.compact_word = cw;
    it.big          = random_value();
    return it;
  endfunction

  function automatic cdc_pkg::item_t encode_item(logic [cdc_pkg::ValueW-1:0] v);
    cdc_pkg::item_t it;
    it.kind         = cdc_pkg::KIND_ENCODE;
    it.compact_word = $urandom;
    it.big          = v;
    return it;
  endfunction

  // Compact word with exponents clustered around the shift boundaries
  function automatic logic [cdc_pkg::CompactW-1:0] shaped_compact();
    logic [cdc_pkg::ExpW-1:0]  e;
    logic [cdc_pkg::MantW-1:0] m;
    logic                      sign;
    int unsigned               nbytes;
    e = ($urandom_range(0, 9) < 7) ? cdc_pkg::ExpW'($urandom_range(0, 40)) :
                                     cdc_pkg::ExpW'($urandom);
    m = cdc_pkg::MantW'($urandom);
    nbytes = $urandom_range(0, 3);
    if (nbytes < 3) m = m & cdc_pkg::MantW'((1 << (8 * nbytes)) - 1);
    sign = ($urandom_range(0, 6) == 0);
    return {e, sign, m};
  endfunction

  // Value with a random number of significant bytes
  function automatic logic [cdc_pkg::ValueW-1:0] shaped_value();
    logic [cdc_pkg::ValueW-1:0] v;
    int unsigned                nbytes;
    v = random_value();
    nbytes = $urandom_range(0, cdc_pkg::NumBytes);
    if (nbytes < cdc_pkg::NumBytes) v = v & ((cdc_pkg::ValueW'(1) << (8 * nbytes)) - 1'b1);
    if (nbytes > 0) begin
      if ($urandom_range(0, 2) == 0) v[8*nbytes-1] = 1'b1;
      if ($urandom_range(0, 3) == 0) v = v & (cdc_pkg::ValueW'(8'hff) << (8 * (nbytes - 1)));
    end
    return v;
  endfunction

  function automatic cdc_pkg::item_t random_item();
    cdc_pkg::item_t it;
    case ($urandom_range(0, 4))
      0, 1: it = decode_item(shaped_compact());
      2, 3: it = encode_item(shaped_value());
      default: begin
        it.kind         = 1'($urandom_range(0, 1));
        it.compact_word = $urandom;
        it.big          = random_value();
      end
    endcase
    return it;
  endfunction

  // Offer one transaction after a random gap and hold it until accepted
  task automatic send_item(cdc_pkg::item_t it);
    int unsigned gap;
    bit          accepted;
    gap = src_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.kind         <= it.kind;
    in_if.compact_word <= it.compact_word;
    in_if.big_word_0   <= it.big[63:0];
    in_if.big_word_1   <= it.big[127:64];
    in_if.big_word_2   <= it.big[191:128];
    in_if.big_word_3   <= it.big[255:192];
    // Sample ready while it is stable ahead of the edge
    do begin
      @(negedge clk_i);
      accepted = in_if.ready;
      @(posedge clk_i);
    end while (!accepted);
    checker_h.note_input(it);
  endtask

  // Hold off the sender until every pending result is back
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (checker_h.expected_conversions.size() != 0);
  endtask

  // Cycle limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Result sink with random stalls
  initial begin
    int unsigned   stall;
    bit            taken;
    cdc_pkg::res_t got;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = sink_calm ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      // Capture the offered transaction ahead of the accepting edge
      do begin
        @(negedge clk_i);
        taken      = out_if.valid;
        got.value  = {out_if.value_word_3, out_if.value_word_2,
                      out_if.value_word_1, out_if.value_word_0};
        got.ovf    = out_if.overflow_flag;
        got.normal = out_if.normal_word;
        @(posedge clk_i);
      end while (!taken);
      checker_h.check_result(got);
    end
  end

  // Main sequence
  initial begin
    cdc_pkg::item_t directed[$];
    int unsigned    per_phase;
    checker_h = new();
    src_calm  = 1'b0;
    sink_calm = 1'b0;
    rst_ni             <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.kind         <= cdc_pkg::KIND_DECODE;
    in_if.compact_word <= '0;
    in_if.big_word_0   <= '0;
    in_if.big_word_1   <= '0;
    in_if.big_word_2   <= '0;
    in_if.big_word_3   <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Decode: shifts right, shifts left, sign, overflow edges, zero mantissa
    directed.push_back(decode_item(32'h0000_0000));
    directed.push_back(decode_item(32'h0012_3456));
    directed.push_back(decode_item(32'h0112_3456));
    directed.push_back(decode_item(32'h0212_3456));
    directed.push_back(decode_item(32'h0312_3456));
    directed.push_back(decode_item(32'h0412_3456));
    directed.push_back(decode_item(32'h007f_ffff));
    directed.push_back(decode_item(32'h1d00_ffff));
    directed.push_back(decode_item(32'h0492_3456));
    directed.push_back(decode_item(32'hffff_ffff));
    directed.push_back(decode_item(32'h207f_ffff));
    directed.push_back(decode_item(32'h217f_ffff));
    directed.push_back(decode_item(32'h2200_00ff));
    directed.push_back(decode_item(32'h2300_00ff));
    directed.push_back(decode_item(32'h2200_ffff));
    directed.push_back(decode_item(32'hff00_0000));
    directed.push_back(decode_item(32'hff00_0001));
    directed.push_back(decode_item(32'h0400_8000));
    // Encode: zero, all ones, low bytes, top byte, exponent bump
    directed.push_back(encode_item('0));
    directed.push_back(encode_item('1));
    directed.push_back(encode_item(cdc_pkg::ValueW'(1)));
    directed.push_back(encode_item(cdc_pkg::ValueW'(8'h80)));
    directed.push_back(encode_item(cdc_pkg::ValueW'(1) << (cdc_pkg::ValueW - 1)));
    directed.push_back(encode_item(cdc_pkg::ValueW'(8'h7f) << (cdc_pkg::ValueW - 8)));
    directed.push_back(encode_item(cdc_pkg::ValueW'(24'h80_0000)));
    foreach (directed[i]) send_item(directed[i]);
    drain_results();

    // Random phases with and without idling on each side
    per_phase = RandomItems / NumPhases;
    for (int phase = 0; phase < NumPhases; phase++) begin
      src_calm  = (phase == 2) || ($urandom_range(0, 3) == 0);
      sink_calm = (phase == 2) || (phase == 5) || ($urandom_range(0, 3) == 0);
      for (int n = 0; n < per_phase; n++) send_item(random_item());
      if (phase == 3) drain_results();
    end
    in_if.valid <= 1'b0;

    // Wait for the pipeline to empty
    while (checker_h.expected_conversions.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (checker_h.mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- compact_target_codec.f -----
rtl/core/cdc_pkg.sv
rtl/core/cdc_if.sv
rtl/core/cdc_decode.sv
rtl/core/cdc_scan.sv
rtl/core/cdc_norm.sv
rtl/core/compact_target_codec.sv
verif/compact_target_codec_test.sv
